### design/aabb_collision_resolve_macros.svh
// Assertion helpers for the collision resolve RTL.
`ifndef AABB_COLLISION_RESOLVE_MACROS_SVH
`define AABB_COLLISION_RESOLVE_MACROS_SVH

`ifndef SYNTHESIS
`define ACR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acr assertion failed");
`define ACR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acr assertion failed");
`else
`define ACR_ASSERT_SAME(label, clk, rst, ante, cons)
`define ACR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### design/acr_pkg.sv
`timescale 1ns / 1ps

package acr_pkg;

  localparam int POS_W  = 20;
  localparam int SIZE_W = 16;
  // wide enough for doubled centres, their difference and the depth sums
  localparam int CALC_W = 24;

  localparam logic [SIZE_W-1:0] MOVER_SIZE_RESET = 16'd480;

  typedef enum logic [0:0] {
    OP_LOAD    = 1'b0,
    OP_RESOLVE = 1'b1
  } acr_op_t;

  typedef enum logic [1:0] {
    HIT_NONE  = 2'd0,
    HIT_HORIZ = 2'd1,
    HIT_VERT  = 2'd2
  } acr_hit_t;

  typedef enum logic [0:0] {
    REG_MOVER_WIDTH  = 1'b0,
    REG_MOVER_HEIGHT = 1'b1
  } acr_reg_t;

  typedef struct packed {
    acr_op_t                  op;
    logic signed [POS_W-1:0]  load_x;
    logic signed [POS_W-1:0]  load_y;
    logic signed [POS_W-1:0]  box_x;
    logic signed [POS_W-1:0]  box_y;
    logic        [SIZE_W-1:0] box_w;
    logic        [SIZE_W-1:0] box_h;
  } acr_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    top_flag;
    acr_hit_t                kind;
  } acr_result_t;

endpackage

### design/acr_resolve.sv
`timescale 1ns / 1ps

module acr_resolve (
  input  acr_pkg::acr_item_t                item,
  input  logic signed [acr_pkg::POS_W-1:0]  pos_x,
  input  logic signed [acr_pkg::POS_W-1:0]  pos_y,
  input  logic                              top_flag,
  input  logic        [acr_pkg::SIZE_W-1:0] mover_w,
  input  logic        [acr_pkg::SIZE_W-1:0] mover_h,
  output acr_pkg::acr_result_t              result
);
  import acr_pkg::*;

  localparam int PAD_W = CALC_W - SIZE_W;

  logic signed [CALC_W-1:0] mx, my, mw, mh, bx, by, bw, bh;
  logic signed [CALC_W-1:0] dx, dy, adx, ady, depx, depy, pushx, pushy;
  logic signed [CALC_W-1:0] nx, ny;
  logic                     hit, horiz, below;

  always_comb begin
    mx = CALC_W'(pos_x);
    my = CALC_W'(pos_y);
    bx = CALC_W'(item.box_x);
    by = CALC_W'(item.box_y);
    mw = {{PAD_W{1'b0}}, mover_w};
    mh = {{PAD_W{1'b0}}, mover_h};
    bw = {{PAD_W{1'b0}}, item.box_w};
    bh = {{PAD_W{1'b0}}, item.box_h};

    // strict overlap; touching edges do not count
    hit = (bx < mx + mw) && (bx + bw > mx) && (by < my + mh) && (by + bh > my);

    // doubled centre offsets, static minus mover
    dx = ((bx <<< 1) + bw) - ((mx <<< 1) + mw);
    dy = ((by <<< 1) + bh) - ((my <<< 1) + mh);
    adx = dx[CALC_W-1] ? -dx : dx;
    ady = dy[CALC_W-1] ? -dy : dy;
    depx = bw + mw - adx;
    depy = bh + mh - ady;

    // a tie goes vertical
    horiz = depx < depy;
    below = !dy[CALC_W-1] && (dy != '0);
    pushx = depx >>> 1;
    pushy = depy >>> 1;

    // zero offset counts as positive: push towards negative
    nx = dx[CALC_W-1] ? mx + pushx : mx - pushx;
    ny = dy[CALC_W-1] ? my + pushy : my - pushy;

    result.pos_x    = pos_x;
    result.pos_y    = pos_y;
    result.top_flag = top_flag;
    result.kind     = HIT_NONE;
    if (item.op == OP_LOAD) begin
      result.pos_x    = item.load_x;
      result.pos_y    = item.load_y;
      result.top_flag = 1'b0;
    end else if (hit) begin
      if (horiz) begin
        result.pos_x = nx[POS_W-1:0];
        result.kind  = HIT_HORIZ;
      end else begin
        result.pos_y = ny[POS_W-1:0];
        result.kind  = HIT_VERT;
        if (below) begin
          result.top_flag = 1'b1;
        end
      end
    end
  end

endmodule

### design/aabb_collision_resolve.sv
`timescale 1ns / 1ps
// Resolves a moving box against a stream of static boxes, one item per clock
// while the output is not stalled. An accepted item is held in an input
// register; the resolve logic (overlap test, doubled-centre depths, push along
// the shallower axis) runs on it in one pass, and the position registers take
// its result once the output slot is free or being drained. Throughput is one
// item per cycle unless out_ready holds the output; the clock rate is set by
// that single resolve path. The output position and on_top flag are the live
// state registers, which only change when the previous result has been taken.
// Write the size registers only while the block is idle.

`include "aabb_collision_resolve_macros.svh"

module aabb_collision_resolve (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic        [acr_pkg::SIZE_W-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              opcode,
  input  logic signed [acr_pkg::POS_W-1:0]  load_x,
  input  logic signed [acr_pkg::POS_W-1:0]  load_y,
  input  logic signed [acr_pkg::POS_W-1:0]  box_x,
  input  logic signed [acr_pkg::POS_W-1:0]  box_y,
  input  logic        [acr_pkg::SIZE_W-1:0] box_w,
  input  logic        [acr_pkg::SIZE_W-1:0] box_h,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [acr_pkg::POS_W-1:0]  mover_x,
  output logic signed [acr_pkg::POS_W-1:0]  mover_y,
  output logic        [1:0]                 hit_kind,
  output logic                              on_top
);
  import acr_pkg::*;

  logic [SIZE_W-1:0]       mover_w;
  logic [SIZE_W-1:0]       mover_h;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    top_flag;
  logic                    in_vld;
  acr_item_t               item;
  acr_hit_t                kind;
  acr_result_t             res;
  logic                    adv;

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mover_w <= MOVER_SIZE_RESET;
      mover_h <= MOVER_SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_MOVER_WIDTH) begin
        mover_w <= cfg_data;
      end else begin
        mover_h <= cfg_data;
      end
    end
  end

  // advance the held item once the output slot is free or being drained
  assign adv      = in_vld && (!out_valid || out_ready);
  assign in_ready = !in_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld <= 1'b1;
    end else if (adv) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.op     <= acr_op_t'(opcode);
      item.load_x <= load_x;
      item.load_y <= load_y;
      item.box_x  <= box_x;
      item.box_y  <= box_y;
      item.box_w  <= box_w;
      item.box_h  <= box_h;
    end
  end

  acr_resolve u_resolve (
    .item     (item),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .top_flag (top_flag),
    .mover_w  (mover_w),
    .mover_h  (mover_h),
    .result   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= '0;
      pos_y     <= '0;
      top_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        pos_x     <= res.pos_x;
        pos_y     <= res.pos_y;
        top_flag  <= res.top_flag;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind <= res.kind;
    end
  end

  assign mover_x  = pos_x;
  assign mover_y  = pos_y;
  assign on_top   = top_flag;
  assign hit_kind = kind;

  `ACR_ASSERT_NEXT(a_load_clears_top, clk, rst, !rst && adv && item.op == OP_LOAD, out_valid && !on_top)
  `ACR_ASSERT_NEXT(a_top_sticky, clk, rst, !rst && adv && item.op == OP_RESOLVE && top_flag, on_top)
  `ACR_ASSERT_NEXT(a_horiz_keeps_y, clk, rst, !rst && adv && item.op == OP_RESOLVE, mover_y == $past(pos_y) || hit_kind == HIT_VERT)
  `ACR_ASSERT_NEXT(a_miss_keeps_pos, clk, rst, !rst && adv && item.op == OP_RESOLVE, hit_kind != HIT_NONE || (mover_x == $past(pos_x) && mover_y == $past(pos_y)))

endmodule
